// ===== src/audio_jitter_buffer_gap_concealer_core_macros.svh =====
// assertion macros shared by the jitter buffer gap concealer rtl
`ifndef AUDIO_JITTER_BUFFER_GAP_CONCEALER_CORE_MACROS_SVH
`define AUDIO_JITTER_BUFFER_GAP_CONCEALER_CORE_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define AJBGC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// property that must hold in the cycle after its trigger
`define AJBGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ajbgc_pkg.sv =====
// shared types and constants of the jitter buffer gap concealer
package ajbgc_pkg;

   localparam int RING_FRAMES_DEFAULT      = 2048;
   localparam int WARMUP_PACKETS_DEFAULT   = 10;
   localparam int MAX_PACKET_BYTES_DEFAULT = 8192;
   localparam int HEADER_BYTES             = 16;

   localparam int SEQ_W      = 32;
   localparam int COUNT_W    = 32;
   localparam int PAYLOAD_W  = 13;
   localparam int READ_W     = 12;
   localparam int BPF_W      = 7;
   localparam int WARMUP_W   = 4;
   localparam int LEVEL_W    = 12;

   localparam logic [BPF_W-1:0] BPF_RESET = 7'd4;

   localparam logic REQ_PACKET = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   typedef enum logic [2:0] {
      GAP_NONE      = 3'd0,
      GAP_CONCEALED = 3'd1,
      GAP_FAILED    = 3'd2,
      GAP_RESYNC    = 3'd3,
      GAP_WARMUP    = 3'd4
   } gap_action_type;

   typedef enum logic [1:0] {
      PAY_STORED   = 2'd0,
      PAY_MISMATCH = 2'd1,
      PAY_DROP     = 2'd2,
      PAY_NONE     = 2'd3
   } payload_action_type;

   typedef struct packed {
      logic [COUNT_W-1:0] discontinuity;
      logic [COUNT_W-1:0] lost_frame;
      logic [COUNT_W-1:0] conceal_fail;
      logic [COUNT_W-1:0] resync;
      logic [COUNT_W-1:0] drop;
      logic [COUNT_W-1:0] mismatch;
   } counters_type;

   typedef struct packed {
      gap_action_type     gap_action;
      payload_action_type payload_action;
      logic [READ_W-1:0]  frames_delivered;
      logic [READ_W-1:0]  frames_short;
   } result_type;

endpackage

// ===== src/ajbgc_step.sv =====
// per-request evaluation: gap handling, payload check, read drain and next state
module ajbgc_step #(
   parameter int  RING_FRAMES      = ajbgc_pkg::RING_FRAMES_DEFAULT,
   parameter int  MAX_PACKET_BYTES = ajbgc_pkg::MAX_PACKET_BYTES_DEFAULT,
   localparam int FILL_W           = $clog2(RING_FRAMES + 1)
) (
   input  logic                             req_type,
   input  logic [ajbgc_pkg::SEQ_W-1:0]      seq_number,
   input  logic [ajbgc_pkg::COUNT_W-1:0]    frame_count,
   input  logic [ajbgc_pkg::PAYLOAD_W-1:0]  payload_bytes,
   input  logic [ajbgc_pkg::READ_W-1:0]     read_frames,
   input  logic [ajbgc_pkg::BPF_W-1:0]      bytes_per_frame,
   input  logic [ajbgc_pkg::SEQ_W-1:0]      expected_seq,
   input  logic [ajbgc_pkg::WARMUP_W-1:0]   warmup_left,
   input  logic [FILL_W-1:0]                ring_fill,
   input  ajbgc_pkg::counters_type          counters,
   output logic [ajbgc_pkg::SEQ_W-1:0]      expected_seq_in,
   output logic [ajbgc_pkg::WARMUP_W-1:0]   warmup_left_in,
   output logic [FILL_W-1:0]                ring_fill_in,
   output ajbgc_pkg::counters_type          counters_in,
   output ajbgc_pkg::result_type            result
);

   localparam int LIMIT  = MAX_PACKET_BYTES - ajbgc_pkg::HEADER_BYTES;
   localparam int PROD_W = 2 * FILL_W;
   localparam int CMP_W  = FILL_W + ajbgc_pkg::READ_W;
   localparam int PAY_PROD_W = ajbgc_pkg::PAYLOAD_W + ajbgc_pkg::BPF_W;
   localparam logic [FILL_W-1:0] RING_FULL = FILL_W'(RING_FRAMES);

   logic [ajbgc_pkg::SEQ_W-1:0]     gap;
   logic [PROD_W-1:0]               missing_prod;
   logic                            missing_big;
   logic [FILL_W-1:0]               missing;
   logic [FILL_W-1:0]               room_before;
   logic [FILL_W-1:0]               fill_mid;
   logic [FILL_W-1:0]               room_mid;
   logic [ajbgc_pkg::PAYLOAD_W-1:0] pbytes_clamped;
   logic [PAY_PROD_W-1:0]           pay_prod;
   logic                            size_mismatch;
   logic                            read_all;
   logic [ajbgc_pkg::READ_W-1:0]    delivered;

   assign gap = seq_number - expected_seq;

   // both factors are at most the ring size whenever the product can be small
   assign missing_prod = gap[FILL_W-1:0] * frame_count[FILL_W-1:0];
   assign missing_big  = (frame_count != '0) &&
                         ((gap > ajbgc_pkg::SEQ_W'(RING_FRAMES)) ||
                          (frame_count > ajbgc_pkg::COUNT_W'(RING_FRAMES)) ||
                          (missing_prod > PROD_W'(RING_FRAMES)));
   assign missing      = missing_prod[FILL_W-1:0];
   assign room_before  = RING_FULL - ring_fill;

   // receive buffer truncation of the payload length
   assign pbytes_clamped = (32'(payload_bytes) > 32'(LIMIT)) ?
                           ajbgc_pkg::PAYLOAD_W'(LIMIT) : payload_bytes;
   // frame counts past the payload range can only match a zero frame size
   assign pay_prod      = frame_count[ajbgc_pkg::PAYLOAD_W-1:0] * bytes_per_frame;
   assign size_mismatch = (PAY_PROD_W'(pbytes_clamped) != pay_prod) ||
                          ((frame_count[ajbgc_pkg::COUNT_W-1:ajbgc_pkg::PAYLOAD_W] != '0) &&
                           (bytes_per_frame != '0));

   assign read_all  = CMP_W'(read_frames) < CMP_W'(ring_fill);
   assign delivered = read_all ? read_frames : ajbgc_pkg::READ_W'(ring_fill);

   always_comb begin
      expected_seq_in        = expected_seq;
      warmup_left_in         = warmup_left;
      ring_fill_in           = ring_fill;
      counters_in            = counters;
      result.gap_action      = ajbgc_pkg::GAP_NONE;
      result.payload_action  = ajbgc_pkg::PAY_NONE;
      result.frames_delivered = '0;
      result.frames_short     = '0;
      fill_mid               = ring_fill;
      room_mid               = room_before;

      if (req_type == ajbgc_pkg::REQ_READ) begin
         result.frames_delivered = delivered;
         result.frames_short     = read_frames - delivered;
         ring_fill_in            = ring_fill - FILL_W'(delivered);
      end else if (warmup_left != '0) begin
         warmup_left_in    = warmup_left - ajbgc_pkg::WARMUP_W'(1);
         expected_seq_in   = seq_number + ajbgc_pkg::SEQ_W'(1);
         result.gap_action = ajbgc_pkg::GAP_WARMUP;
      end else begin
         if (gap != '0) begin
            counters_in.discontinuity = counters.discontinuity + ajbgc_pkg::COUNT_W'(1);
            if (missing_big) begin
               counters_in.resync = counters.resync + ajbgc_pkg::COUNT_W'(1);
               result.gap_action  = ajbgc_pkg::GAP_RESYNC;
            end else begin
               counters_in.lost_frame = counters.lost_frame + ajbgc_pkg::COUNT_W'(missing);
               if (missing <= room_before) begin
                  fill_mid          = ring_fill + missing;
                  room_mid          = room_before - missing;
                  result.gap_action = ajbgc_pkg::GAP_CONCEALED;
               end else begin
                  counters_in.conceal_fail = counters.conceal_fail +
                                             ajbgc_pkg::COUNT_W'(1);
                  result.gap_action        = ajbgc_pkg::GAP_FAILED;
               end
            end
         end
         expected_seq_in = seq_number + ajbgc_pkg::SEQ_W'(1);
         ring_fill_in    = fill_mid;

         if (size_mismatch) begin
            counters_in.mismatch  = counters.mismatch + ajbgc_pkg::COUNT_W'(1);
            result.payload_action = ajbgc_pkg::PAY_MISMATCH;
         end else if (frame_count <= ajbgc_pkg::COUNT_W'(room_mid)) begin
            ring_fill_in          = fill_mid + frame_count[FILL_W-1:0];
            result.payload_action = ajbgc_pkg::PAY_STORED;
         end else begin
            counters_in.drop      = counters.drop + ajbgc_pkg::COUNT_W'(1);
            result.payload_action = ajbgc_pkg::PAY_DROP;
         end
      end
   end

endmodule

// ===== src/audio_jitter_buffer_gap_concealer_core.sv =====
// Jitter buffer occupancy tracker with silence concealment of sequence gaps.
// Takes one request per clock when not stalled: a packet arrival (req_type 0)
// or a playback read (req_type 1). An accepted request is captured in the
// input register and evaluated against the buffer state while it sits there;
// its response is loaded into the result register when the input register
// advances, so a new request can follow in every cycle while rsp_stall is low;
// the state update path (gap multiply, room compares, fill add) is the loop
// that sets this rate. A held response stalls the input once the input register
// is also occupied. The fill level and running totals on the response port are
// the state after that request. The user must write bytes_per_frame only while
// no request is in flight, via csr_wr_en/csr_wr_data; the block does not enforce it.
`include "audio_jitter_buffer_gap_concealer_core_macros.svh"

module audio_jitter_buffer_gap_concealer_core #(
   parameter int RING_FRAMES      = ajbgc_pkg::RING_FRAMES_DEFAULT,
   parameter int WARMUP_PACKETS   = ajbgc_pkg::WARMUP_PACKETS_DEFAULT,
   parameter int MAX_PACKET_BYTES = ajbgc_pkg::MAX_PACKET_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ajbgc_pkg::BPF_W-1:0]      csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [ajbgc_pkg::SEQ_W-1:0]      req_seq_number,
   input  logic [ajbgc_pkg::COUNT_W-1:0]    req_frame_count,
   input  logic [ajbgc_pkg::PAYLOAD_W-1:0]  req_payload_bytes,
   input  logic [ajbgc_pkg::READ_W-1:0]     req_read_frames,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_gap_action,
   output logic [1:0]                       rsp_payload_action,
   output logic [ajbgc_pkg::READ_W-1:0]     rsp_frames_delivered,
   output logic [ajbgc_pkg::READ_W-1:0]     rsp_frames_short,
   output logic [ajbgc_pkg::LEVEL_W-1:0]    rsp_fill_level,
   output logic [ajbgc_pkg::COUNT_W-1:0]    rsp_discontinuity_total,
   output logic [ajbgc_pkg::COUNT_W-1:0]    rsp_lost_frame_total,
   output logic [ajbgc_pkg::COUNT_W-1:0]    rsp_conceal_fail_total,
   output logic [ajbgc_pkg::COUNT_W-1:0]    rsp_resync_total,
   output logic [ajbgc_pkg::COUNT_W-1:0]    rsp_drop_total,
   output logic [ajbgc_pkg::COUNT_W-1:0]    rsp_mismatch_total
);

   localparam int FILL_W = $clog2(RING_FRAMES + 1);
   localparam int WIDE_W = FILL_W + ajbgc_pkg::LEVEL_W;

   logic                             in_valid_ff;
   logic                             in_valid_in;
   logic                             in_type_ff;
   logic [ajbgc_pkg::SEQ_W-1:0]      in_seq_ff;
   logic [ajbgc_pkg::COUNT_W-1:0]    in_frames_ff;
   logic [ajbgc_pkg::PAYLOAD_W-1:0]  in_pbytes_ff;
   logic [ajbgc_pkg::READ_W-1:0]     in_read_ff;
   logic                             out_valid_ff;
   logic                             out_valid_in;
   ajbgc_pkg::result_type            result_ff;
   ajbgc_pkg::result_type            result_in;
   logic [ajbgc_pkg::BPF_W-1:0]      bpf_ff;
   logic [ajbgc_pkg::SEQ_W-1:0]      expected_seq_ff;
   logic [ajbgc_pkg::SEQ_W-1:0]      expected_seq_in;
   logic [ajbgc_pkg::WARMUP_W-1:0]   warmup_ff;
   logic [ajbgc_pkg::WARMUP_W-1:0]   warmup_in;
   logic [FILL_W-1:0]                fill_ff;
   logic [FILL_W-1:0]                fill_in;
   ajbgc_pkg::counters_type          counters_ff;
   ajbgc_pkg::counters_type          counters_in;
   logic                             advance;
   logic                             accept;
   logic [WIDE_W-1:0]                fill_wide;

   // the input register moves on whenever the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);

   ajbgc_step #(
      .RING_FRAMES      (RING_FRAMES),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_step (
      .req_type        (in_type_ff),
      .seq_number      (in_seq_ff),
      .frame_count     (in_frames_ff),
      .payload_bytes   (in_pbytes_ff),
      .read_frames     (in_read_ff),
      .bytes_per_frame (bpf_ff),
      .expected_seq    (expected_seq_ff),
      .warmup_left     (warmup_ff),
      .ring_fill       (fill_ff),
      .counters        (counters_ff),
      .expected_seq_in (expected_seq_in),
      .warmup_left_in  (warmup_in),
      .ring_fill_in    (fill_in),
      .counters_in     (counters_in),
      .result          (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_type_ff   <= req_type;
         in_seq_ff    <= req_seq_number;
         in_frames_ff <= req_frame_count;
         in_pbytes_ff <= req_payload_bytes;
         in_read_ff   <= req_read_frames;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpf_ff <= ajbgc_pkg::BPF_RESET;
      end else if (csr_wr_en) begin
         bpf_ff <= csr_wr_data;
      end
   end

   // state only moves with the result register, so it stays matched to a held response
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_seq_ff <= '0;
         warmup_ff       <= ajbgc_pkg::WARMUP_W'(WARMUP_PACKETS);
         fill_ff         <= '0;
         counters_ff     <= '0;
      end else if (advance) begin
         expected_seq_ff <= expected_seq_in;
         warmup_ff       <= warmup_in;
         fill_ff         <= fill_in;
         counters_ff     <= counters_in;
      end
   end

   assign fill_wide = WIDE_W'(fill_ff);

   assign rsp_valid               = out_valid_ff;
   assign rsp_gap_action          = result_ff.gap_action;
   assign rsp_payload_action      = result_ff.payload_action;
   assign rsp_frames_delivered    = result_ff.frames_delivered;
   assign rsp_frames_short        = result_ff.frames_short;
   assign rsp_fill_level          = fill_wide[ajbgc_pkg::LEVEL_W-1:0];
   assign rsp_discontinuity_total = counters_ff.discontinuity;
   assign rsp_lost_frame_total    = counters_ff.lost_frame;
   assign rsp_conceal_fail_total  = counters_ff.conceal_fail;
   assign rsp_resync_total        = counters_ff.resync;
   assign rsp_drop_total          = counters_ff.drop;
   assign rsp_mismatch_total      = counters_ff.mismatch;

   `AJBGC_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1,
      fill_ff <= FILL_W'(RING_FRAMES), "ring fill above ring size")
   `AJBGC_ASSERT_NOW(a_held_no_advance, clock, reset, out_valid_ff && rsp_stall,
      !advance, "state advanced under a held response")
   `AJBGC_ASSERT_NOW(a_warmup_quiet, clock, reset, warmup_ff != '0,
      counters_ff == '0, "counters moved during warmup")
   `AJBGC_ASSERT_NEXT(a_idle_state, clock, reset, !advance,
      $stable(fill_ff) && $stable(counters_ff), "state changed without a request")

endmodule
